// ----- sv/pbcp_pkg.sv -----
// Shared types, constants and the credit settle function of the packet byte credit pacer.
`default_nettype none

package pbcp_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W     = 32;

    // Field and register widths
    localparam int HANDLE_W    = 16;
    localparam int LENGTH_W    = 16;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 20;
    localparam int INTERVAL_W  = 8;
    localparam int FORGIVE_W   = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CREDIT_W    = 32;

    // Budget = (elapsed * rate) >> 3
    localparam int PROD_W      = INTERVAL_W + RATE_W;
    localparam int BUDGET_SHIFT = 3;
    localparam int BUDGET_W    = PROD_W - BUDGET_SHIFT;

    // Running credit during a tick: signed, with headroom above the credit width
    localparam int RUN_W       = CREDIT_W + 2;

    // Reset and default values
    localparam logic [RATE_W-1:0]     DEFAULT_RATE     = RATE_W'(10240);
    localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL = INTERVAL_W'(4);
    localparam logic [FORGIVE_W-1:0]  DEFAULT_FORGIVE  = FORGIVE_W'(1500);
    localparam logic [CREDIT_W-1:0]   CREDIT_MAX       = 32'h7FFF_FFFF;

    // Input commands
    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_TICK    = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_KBPS       = 2'd0,
        CFG_MAX_INTERVAL_MS = 2'd1,
        CFG_DEBT_FORGIVE    = 2'd2
    } t_cfg_idx;

    // Clamp a running credit: saturate high, forgive deep debt
    function automatic logic signed [CREDIT_W-1:0] settle(
        input logic signed [RUN_W-1:0] v,
        input logic [FORGIVE_W-1:0]    lim
    );
        logic signed [RUN_W-1:0] neg_lim;
        logic signed [RUN_W-1:0] pos_max;
        neg_lim = -$signed({{(RUN_W-FORGIVE_W){1'b0}}, lim});
        pos_max = $signed({{(RUN_W-CREDIT_W){1'b0}}, CREDIT_MAX});
        if (v > pos_max) begin
            settle = $signed(CREDIT_MAX);
        end else if (v <= neg_lim) begin
            settle = '0;
        end else begin
            settle = v[CREDIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/packet_byte_credit_pacer.sv -----
// Top level of the packet byte credit pacer: queue control, credit state and result register.
// An enqueue transaction stores the packet in a 64-entry queue RAM, or flags it dropped when
// the queue is full. A tick with no elapsed time reports the fill and changes nothing. Any
// other tick captures and caps the elapsed time, multiplies it by the rate, adds the stored
// credit and, when packets leave, releases them from the head of the queue RAM, whose next
// read is issued as each packet is emitted. Each input transaction yields one or more result
// transactions; the final one has o_last set. Output stalls hold the sequencer before each
// result is loaded. A configuration write takes effect at once, so write the registers only
// while the block is idle with no transaction in flight.
`default_nettype none

module packet_byte_credit_pacer
    import pbcp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [HANDLE_W-1:0]   i_packet_handle,
    input  wire logic [LENGTH_W-1:0]   i_packet_length,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    // Output channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic                  o_released,
    output      logic [HANDLE_W-1:0]   o_out_handle,
    output      logic [LENGTH_W-1:0]   o_out_length,
    output      logic                  o_dropped,
    output      logic [FILL_W-1:0]     o_queue_count,
    output      logic                  o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MULT = 4'b0010,
        S_SUM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [RATE_W-1:0]     r_rate_kbps;
    logic [INTERVAL_W-1:0] r_max_interval;
    logic [FORGIVE_W-1:0]  r_forgive;

    // Queue pointers and credit state
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [FILL_W-1:0]          r_fill, n_fill;
    logic signed [CREDIT_W-1:0] r_credit, n_credit;
    logic [TIME_W-1:0]          r_last_send, n_last_send;

    // Tick working registers
    logic [TIME_W-1:0]          r_now, n_now;
    logic [INTERVAL_W-1:0]      r_elapsed, n_elapsed;
    logic signed [RUN_W-1:0]    r_run, n_run;
    logic [CNT_W-1:0]           r_cnt, n_cnt;

    // Result register
    logic                  r_out_valid, n_out_valid;
    logic                  r_released, n_released;
    logic [HANDLE_W-1:0]   r_handle, n_handle;
    logic [LENGTH_W-1:0]   r_length, n_length;
    logic                  r_dropped, n_dropped;
    logic [FILL_W-1:0]     r_count, n_count;
    logic                  r_last, n_last;
    logic                  w_load;

    // Queue RAM ports
    logic               w_ram_we;
    logic [PTR_W-1:0]   w_ram_waddr;
    logic [ENTRY_W-1:0] w_ram_wdata;
    logic               w_ram_re;
    logic [PTR_W-1:0]   w_ram_raddr;
    logic [ENTRY_W-1:0] w_ram_rdata;

    logic [BUDGET_W-1:0] w_budget;

    // Combinational helpers
    logic                    w_out_free;
    logic                    w_accept;
    logic [TIME_W-1:0]       w_elapsed_full;
    logic signed [RUN_W-1:0] w_sum;
    logic signed [RUN_W-1:0] w_run_after;
    logic [LENGTH_W-1:0]     w_len;
    logic [FILL_W-1:0]       w_fill_dec;
    logic [PTR_W-1:0]        w_head_inc;
    logic [PTR_W-1:0]        w_tail_inc;
    logic                    w_fin;

    pbcp_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    pbcp_budget u_budget (
        .i_clk       (i_clk),
        .i_elapsed   (r_elapsed),
        .i_rate_kbps (r_rate_kbps),
        .o_budget    (w_budget)
    );

    // Handshake and datapath helpers
    assign w_out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready     = (r_state == S_IDLE) && w_out_free;
    assign w_accept       = i_in_valid && o_in_ready;
    assign w_elapsed_full = i_now_ms - r_last_send;
    assign w_sum          = $signed({{(RUN_W-BUDGET_W){1'b0}}, w_budget})
                          + $signed({{(RUN_W-CREDIT_W){r_credit[CREDIT_W-1]}}, r_credit});
    assign w_len          = w_ram_rdata[LENGTH_W-1:0];
    assign w_run_after    = r_run - $signed({{(RUN_W-LENGTH_W){1'b0}}, w_len});
    assign w_fill_dec     = r_fill - FILL_W'(1);
    assign w_head_inc     = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_tail_inc     = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign w_fin          = (w_run_after <= 0) || (w_fill_dec == '0)
                          || ((r_cnt + CNT_W'(1)) >= CNT_W'(MAX_RESULTS));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_credit    = r_credit;
        n_last_send = r_last_send;
        n_now       = r_now;
        n_elapsed   = r_elapsed;
        n_run       = r_run;
        n_cnt       = r_cnt;
        w_load      = 1'b0;
        n_released  = r_released;
        n_handle    = r_handle;
        n_length    = r_length;
        n_dropped   = r_dropped;
        n_count     = r_count;
        n_last      = r_last;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_tail;
        w_ram_wdata = {i_packet_handle, i_packet_length};
        w_ram_re    = 1'b0;
        w_ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_cmd'(i_command) == CMD_ENQUEUE) begin
                        // Store or drop the packet, one result
                        w_load     = 1'b1;
                        n_released = 1'b0;
                        n_handle   = '0;
                        n_length   = '0;
                        n_last     = 1'b1;
                        if (r_fill >= FILL_W'(QUEUE_DEPTH)) begin
                            n_dropped = 1'b1;
                            n_count   = r_fill;
                        end else begin
                            w_ram_we  = 1'b1;
                            n_tail    = w_tail_inc;
                            n_fill    = r_fill + FILL_W'(1);
                            n_dropped = 1'b0;
                            n_count   = r_fill + FILL_W'(1);
                        end
                    end else if (w_elapsed_full == '0) begin
                        // No time has passed: report and change nothing
                        w_load     = 1'b1;
                        n_released = 1'b0;
                        n_handle   = '0;
                        n_length   = '0;
                        n_dropped  = 1'b0;
                        n_count    = r_fill;
                        n_last     = 1'b1;
                    end else begin
                        // Capture time and cap the elapsed interval
                        n_now     = i_now_ms;
                        n_elapsed = (w_elapsed_full > TIME_W'(r_max_interval))
                                  ? r_max_interval : w_elapsed_full[INTERVAL_W-1:0];
                        n_state   = S_MULT;
                    end
                end
            end

            S_MULT: begin
                n_state = S_SUM;
            end

            S_SUM: begin
                if (w_sum > 0 && r_fill != '0) begin
                    // Start releasing: fetch the queue head
                    n_run    = w_sum;
                    n_cnt    = '0;
                    w_ram_re = 1'b1;
                    n_state  = S_EMIT;
                end else if (w_out_free) begin
                    w_load     = 1'b1;
                    n_released = 1'b0;
                    n_handle   = '0;
                    n_length   = '0;
                    n_dropped  = 1'b0;
                    n_count    = r_fill;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                    // Debt or zero: settle the credit without sending
                    if (w_sum <= 0) begin
                        n_credit    = settle(w_sum, r_forgive);
                        n_last_send = r_now;
                    end
                end
            end

            S_EMIT: begin
                if (w_out_free) begin
                    // Release the fetched packet
                    w_load     = 1'b1;
                    n_released = 1'b1;
                    n_handle   = w_ram_rdata[ENTRY_W-1:LENGTH_W];
                    n_length   = w_len;
                    n_dropped  = 1'b0;
                    n_count    = w_fill_dec;
                    n_last     = w_fin;
                    n_head     = w_head_inc;
                    n_fill     = w_fill_dec;
                    n_run      = w_run_after;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (w_fin) begin
                        n_credit    = settle(w_run_after, r_forgive);
                        n_last_send = r_now;
                        n_state     = S_IDLE;
                    end else begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = w_head_inc;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_credit    <= '0;
            r_last_send <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_credit    <= n_credit;
            r_last_send <= n_last_send;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_kbps    <= DEFAULT_RATE;
            r_max_interval <= DEFAULT_INTERVAL;
            r_forgive      <= DEFAULT_FORGIVE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_KBPS:       r_rate_kbps    <= i_cfg_wdata[RATE_W-1:0];
                CFG_MAX_INTERVAL_MS: r_max_interval <= i_cfg_wdata[INTERVAL_W-1:0];
                CFG_DEBT_FORGIVE:    r_forgive      <= i_cfg_wdata[FORGIVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_elapsed  <= n_elapsed;
        r_run      <= n_run;
        r_cnt      <= n_cnt;
        r_released <= n_released;
        r_handle   <= n_handle;
        r_length   <= n_length;
        r_dropped  <= n_dropped;
        r_count    <= n_count;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_released    = r_released;
    assign o_out_handle  = r_handle;
    assign o_out_length  = r_length;
    assign o_dropped     = r_dropped;
    assign o_queue_count = r_count;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// ----- sv/pbcp_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module pbcp_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/pbcp_budget.sv -----
// Byte budget unit: capped elapsed time times the effective rate, scaled to bytes.
`default_nettype none

module pbcp_budget
    import pbcp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [INTERVAL_W-1:0] i_elapsed,
    input  wire logic [RATE_W-1:0]     i_rate_kbps,
    output      logic [BUDGET_W-1:0]   o_budget
);

    logic [RATE_W-1:0] w_rate;
    logic [PROD_W-1:0] w_prod;

    // Substitute the default rate for zero, then multiply
    assign w_rate = (i_rate_kbps == '0) ? DEFAULT_RATE : i_rate_kbps;
    assign w_prod = PROD_W'(i_elapsed) * PROD_W'(w_rate);

    // Register the scaled product
    always_ff @(posedge i_clk) begin
        o_budget <= w_prod[PROD_W-1:BUDGET_SHIFT];
    end

endmodule

`default_nettype wire

// ----- dv/pacer_checker.sv -----
// Scoreboard for the packet byte credit pacer: shadow queue and credit, per-field result compare.
`timescale 1ns / 1ps

module pacer_checker
    import pbcp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input channel
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_command,
    input  logic [HANDLE_W-1:0]   i_packet_handle,
    input  logic [LENGTH_W-1:0]   i_packet_length,
    input  logic [TIME_W-1:0]     i_now_ms,
    // Output channel
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_released,
    input  logic [HANDLE_W-1:0]   i_out_handle,
    input  logic [LENGTH_W-1:0]   i_out_length,
    input  logic                  i_dropped,
    input  logic [FILL_W-1:0]     i_queue_count,
    input  logic                  i_last,
    // Status toward the testbench top
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_items,
    output int                    o_results,
    output int                    o_releases,
    output int                    o_drops
);

    localparam int REPORT_LIMIT = 10;
    localparam int EXP_DEPTH    = 256;

    typedef struct packed {
        logic                released;
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
        logic                dropped;
        logic [FILL_W-1:0]   count;
        logic                last;
    } t_pacer_result;

    // Expected results waiting for the block, kept as a ring
    t_pacer_result exp_ring [EXP_DEPTH];
    int            exp_rd;
    int            exp_wr;
    int            exp_count;

    // Shadow copy of the pacer state and registers
    logic [HANDLE_W-1:0]        fifo_handle [QUEUE_DEPTH];
    logic [LENGTH_W-1:0]        fifo_length [QUEUE_DEPTH];
    logic [PTR_W-1:0]           rd_ptr;
    logic [PTR_W-1:0]           wr_ptr;
    int                         fill;
    logic signed [CREDIT_W-1:0] credit;
    logic [TIME_W-1:0]          sent_at;
    logic [RATE_W-1:0]          rate_reg;
    logic [INTERVAL_W-1:0]      interval_reg;
    logic [FORGIVE_W-1:0]       forgive_reg;

    int mismatches = 0;
    int items      = 0;
    int results    = 0;
    int releases   = 0;
    int drops      = 0;

    // Saturate a large credit, forgive a debt at or past the limit
    function automatic logic signed [CREDIT_W-1:0] clamp_credit(input longint run);
        if (run > longint'(CREDIT_MAX)) begin
            return CREDIT_MAX;
        end
        if (run <= -longint'(forgive_reg)) begin
            return '0;
        end
        return CREDIT_W'(run);
    endfunction

    // Queue one expected result; the count field reflects the fill after the update
    function automatic void push_result(input logic rel, input logic [HANDLE_W-1:0] hdl,
                                        input logic [LENGTH_W-1:0] len, input logic drop,
                                        input logic fin);
        t_pacer_result r;
        r.released = rel;
        r.handle   = hdl;
        r.length   = len;
        r.dropped  = drop;
        r.count    = FILL_W'(fill);
        r.last     = fin;
        exp_ring[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_count++;
    endfunction

    // Advance the shadow pacer by one input transaction and queue its results
    function automatic void advance_pacer(input t_cmd cmd, input logic [HANDLE_W-1:0] hdl,
                                          input logic [LENGTH_W-1:0] len,
                                          input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0]   elapsed;
        logic [RATE_W-1:0]   eff_rate;
        logic [HANDLE_W-1:0] pkt_handle;
        logic [LENGTH_W-1:0] pkt_len;
        longint              run;
        int                  sent;
        logic                fin;

        if (cmd == CMD_ENQUEUE) begin
            if (fill >= QUEUE_DEPTH) begin
                drops++;
                push_result(1'b0, '0, '0, 1'b1, 1'b1);
            end else begin
                fifo_handle[wr_ptr] = hdl;
                fifo_length[wr_ptr] = len;
                wr_ptr = wr_ptr + 1'b1;
                fill++;
                push_result(1'b0, '0, '0, 1'b0, 1'b1);
            end
            return;
        end

        // No time passed: nothing changes
        elapsed = now - sent_at;
        if (elapsed == '0) begin
            push_result(1'b0, '0, '0, 1'b0, 1'b1);
            return;
        end

        // Byte budget from the capped interval and the effective rate
        if (elapsed > TIME_W'(interval_reg)) begin
            elapsed = TIME_W'(interval_reg);
        end
        eff_rate = (rate_reg == '0) ? DEFAULT_RATE : rate_reg;
        run = (longint'(elapsed) * longint'(eff_rate)) >>> BUDGET_SHIFT;
        run = run + credit;

        // Not enough credit: take the sum, send nothing
        if (run <= 0) begin
            credit  = clamp_credit(run);
            sent_at = now;
            push_result(1'b0, '0, '0, 1'b0, 1'b1);
            return;
        end

        // Credit but nothing to send: state untouched
        if (fill == 0) begin
            push_result(1'b0, '0, '0, 1'b0, 1'b1);
            return;
        end

        // Release from the head until the credit is spent or the per-tick limit is hit
        sent = 0;
        while (fill > 0 && sent < MAX_RESULTS && run > 0) begin
            pkt_handle = fifo_handle[rd_ptr];
            pkt_len    = fifo_length[rd_ptr];
            rd_ptr     = rd_ptr + 1'b1;
            fill--;
            run = run - longint'(pkt_len);
            fin = (run <= 0) || (fill == 0) || (sent + 1 >= MAX_RESULTS);
            push_result(1'b1, pkt_handle, pkt_len, 1'b0, fin);
            sent++;
            releases++;
        end
        credit  = clamp_credit(run);
        sent_at = now;
    endfunction

    // Track config writes, predict accepted items, compare accepted results
    always @(posedge i_clk) begin : scoreboard
        t_pacer_result want;
        if (!i_rst_n) begin
            rd_ptr       = '0;
            wr_ptr       = '0;
            fill         = 0;
            credit       = '0;
            sent_at      = '0;
            rate_reg     = DEFAULT_RATE;
            interval_reg = DEFAULT_INTERVAL;
            forgive_reg  = DEFAULT_FORGIVE;
            exp_rd       = 0;
            exp_wr       = 0;
            exp_count    = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RATE_KBPS:       rate_reg     = i_cfg_wdata[RATE_W-1:0];
                    CFG_MAX_INTERVAL_MS: interval_reg = i_cfg_wdata[INTERVAL_W-1:0];
                    CFG_DEBT_FORGIVE:    forgive_reg  = i_cfg_wdata[FORGIVE_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                items++;
                advance_pacer(t_cmd'(i_command), i_packet_handle, i_packet_length, i_now_ms);
            end

            if (i_out_valid && i_out_ready) begin
                results++;
                if (exp_count == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result rel=%0d handle=%h len=%0d drop=%0d",
                                 $time, i_released, i_out_handle, i_out_length, i_dropped);
                    end
                end else begin
                    want   = exp_ring[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (want.released !== i_released || want.handle !== i_out_handle ||
                        want.length !== i_out_length || want.dropped !== i_dropped ||
                        want.count !== i_queue_count || want.last !== i_last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: mismatch exp rel=%0d handle=%h len=%0d drop=%0d",
                                     $time, want.released, want.handle, want.length,
                                     want.dropped, " count=%0d last=%0d",
                                     want.count, want.last);
                            $display("%0t:          got rel=%0d handle=%h len=%0d drop=%0d",
                                     $time, i_released, i_out_handle, i_out_length,
                                     i_dropped, " count=%0d last=%0d",
                                     i_queue_count, i_last);
                        end
                    end
                end
            end
        end

        o_mismatches <= mismatches;
        o_pending    <= exp_count;
        o_items      <= items;
        o_results    <= results;
        o_releases   <= releases;
        o_drops      <= drops;
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top of the packet byte credit pacer: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps

module tb_top
    import pbcp_pkg::*;
();

    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // Block inputs, all known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  i_command       = 1'b0;
    logic [HANDLE_W-1:0]   i_packet_handle = '0;
    logic [LENGTH_W-1:0]   i_packet_length = '0;
    logic [TIME_W-1:0]     i_now_ms        = '0;
    logic                  i_out_ready     = 1'b0;

    // Block outputs
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_released;
    logic [HANDLE_W-1:0]   o_out_handle;
    logic [LENGTH_W-1:0]   o_out_length;
    logic                  o_dropped;
    logic [FILL_W-1:0]     o_queue_count;
    logic                  o_last;

    // Checker status
    int mismatches;
    int pending;
    int items;
    int results;
    int releases;
    int drops;

    // Stimulus knobs
    int unsigned       in_idle_pct   = 0;
    int unsigned       out_stall_pct = 0;
    int unsigned       hold_reqs     = 0;
    int unsigned       cap_ms        = 4;
    logic [TIME_W-1:0] clock_ms      = '0;

    packet_byte_credit_pacer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_packet_handle (i_packet_handle),
        .i_packet_length (i_packet_length),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_released      (o_released),
        .o_out_handle    (o_out_handle),
        .o_out_length    (o_out_length),
        .o_dropped       (o_dropped),
        .o_queue_count   (o_queue_count),
        .o_last          (o_last)
    );

    pacer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_packet_handle (i_packet_handle),
        .i_packet_length (i_packet_length),
        .i_now_ms        (i_now_ms),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_released      (o_released),
        .i_out_handle    (o_out_handle),
        .i_out_length    (o_out_length),
        .i_dropped       (o_dropped),
        .i_queue_count   (o_queue_count),
        .i_last          (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_items         (items),
        .o_results       (results),
        .o_releases      (releases),
        .o_drops         (drops)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Drive output ready: random stalls, plus a long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
            end
        end
    end

    function automatic logic [LENGTH_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return '0;
        end
        if (roll < 15) begin
            return LENGTH_W'($urandom);
        end
        return LENGTH_W'($urandom_range(20, 1500));
    endfunction

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
            IDLE_SENDER:   begin in_idle_pct = 82; out_stall_pct = 0;  end
            IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 82; end
            default:       begin in_idle_pct = 24; out_stall_pct = 24; end
        endcase
    endtask

    // Offer one transaction, with random idle cycles ahead of it, and hold until taken
    task automatic send_item(input t_cmd cmd, input logic [HANDLE_W-1:0] hdl,
                             input logic [LENGTH_W-1:0] len, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_packet_handle <= hdl;
        i_packet_length <= len;
        i_now_ms        <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected result is back and the block is idle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !o_in_ready) @(posedge i_clk);
    endtask

    // Write all three registers back to back; junk in the unused upper data bits
    task automatic set_config(input logic [RATE_W-1:0] rate, input logic [INTERVAL_W-1:0] ival,
                              input logic [FORGIVE_W-1:0] forgive);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RATE_KBPS;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_INTERVAL_MS;
        i_cfg_wdata <= {(CFG_DATA_W-INTERVAL_W)'($urandom), ival};
        @(posedge i_clk);
        i_cfg_index <= CFG_DEBT_FORGIVE;
        i_cfg_wdata <= {(CFG_DATA_W-FORGIVE_W)'($urandom), forgive};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_ms = ival;
    endtask

    // Mostly enqueue bursts closed by a tick, plus repeated times, jumps and flood bursts
    task automatic run_traffic(input int n_items);
        int sent_n;
        int burst;
        int pick;
        sent_n = 0;
        while (sent_n < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    send_item(CMD_ENQUEUE, HANDLE_W'($urandom), pick_length(), $urandom);
                end
                clock_ms = clock_ms + $urandom_range(1, cap_ms + 3);
                send_item(CMD_TICK, HANDLE_W'($urandom), LENGTH_W'($urandom), clock_ms);
                sent_n += burst + 1;
            end else if (pick < 80) begin
                send_item(CMD_TICK, HANDLE_W'($urandom), LENGTH_W'($urandom), clock_ms);
                sent_n++;
            end else if (pick < 88) begin
                clock_ms = $urandom;
                send_item(CMD_TICK, HANDLE_W'($urandom), LENGTH_W'($urandom), clock_ms);
                sent_n++;
            end else begin
                burst = $urandom_range(8, 24);
                repeat (burst) begin
                    send_item(CMD_ENQUEUE, HANDLE_W'($urandom), pick_length(), $urandom);
                end
                sent_n += burst;
            end
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero elapsed, huge elapsed on an empty queue
        set_idle(IDLE_NONE);
        send_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 32'd0);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        // Field extremes, deep debt forgiven, then a repeated time
        send_item(CMD_ENQUEUE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 32'd0);
        send_item(CMD_ENQUEUE, 16'h1234, 16'd100, 32'd0);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd1);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd1);
        // Queue runs dry with credit left over
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd3);
        // Small debt that is kept
        send_item(CMD_ENQUEUE, 16'hAAAA, 16'd3000, 32'd0);
        send_item(CMD_ENQUEUE, 16'h5555, 16'd1000, 32'd0);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd4);
        send_item(CMD_ENQUEUE, 16'h0F0F, 16'd1500, 32'd0);
        // Tiny budget cannot cover the debt: nothing sent
        drain();
        set_config(20'd8, 8'd1, 16'd1500);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd10);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd10);
        // Interval cap of zero
        drain();
        set_config(20'd8, 8'd0, 16'd1500);
        send_item(CMD_TICK, 16'h0000, 16'h0000, 32'd20);
        clock_ms = 32'd20;

        // Hold the receiver off, overfill the queue, then drain 64 packets in one tick
        drain();
        set_config(20'd524287, 8'd1, 16'd1500);
        hold_reqs <= hold_reqs + 1;
        repeat (65) send_item(CMD_ENQUEUE, HANDLE_W'($urandom), 16'd1000, $urandom);
        clock_ms = clock_ms + 1;
        send_item(CMD_TICK, HANDLE_W'($urandom), LENGTH_W'($urandom), clock_ms);

        // Random traffic under several register settings and idle patterns
        drain();
        set_idle(IDLE_SENDER);
        set_config(20'd0, 8'd4, 16'd1500);
        run_traffic(40);
        drain();
        set_idle(IDLE_RECEIVER);
        set_config(20'd1, 8'd255, 16'd0);
        run_traffic(40);
        drain();
        set_idle(IDLE_BOTH);
        set_config(20'd9000, 8'd0, 16'd65535);
        run_traffic(40);
        drain();
        set_idle(IDLE_NONE);
        set_config(20'd20000, 8'd20, 16'd3000);
        run_traffic(40);

        // Top rate and interval: pile up credit until it saturates
        drain();
        set_idle(IDLE_BOTH);
        set_config(20'hFFFFF, 8'd255, 16'd65535);
        repeat (70) begin
            send_item(CMD_ENQUEUE, HANDLE_W'($urandom), LENGTH_W'($urandom_range(0, 100)),
                      $urandom);
            clock_ms = clock_ms + 255 + $urandom_range(0, 9);
            send_item(CMD_TICK, HANDLE_W'($urandom), LENGTH_W'($urandom), clock_ms);
        end

        // Let everything come back, then watch a little longer for strays
        drain();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d input transactions and %0d result transactions", items, results);
        $display("(%0d packets released, %0d enqueues dropped) under nine register settings",
                 releases, drops);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
